>>> rtl/core/tlsa_pkg.sv
// Shared types, constants and the size hint table of the texture layer slot allocator.
package tlsa_pkg;

  // Table geometry
  localparam int MaxArrays = 64;
  localparam int IdxW      = $clog2(MaxArrays);
  localparam int UsedW     = IdxW + 1;

  // Field widths
  localparam int DimW   = 13;
  localparam int FmtW   = 16;
  localparam int CapW   = 12;
  localparam int LayerW = 11;
  localparam int CfgW   = 12;

  // Stream packing
  localparam int InDataW  = 48;
  localparam int OutDataW = 32;
  localparam int OutUserW = 2;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Capacity saturation limit
  localparam logic [CapW-1:0] CapLimit = 12'd2048;

  // Configuration register indexes and reset values
  localparam logic [0:0] CfgDefaultLayers = 1'b0;
  localparam logic [0:0] CfgMaxLayers     = 1'b1;
  localparam logic [CfgW-1:0] DefaultLayersRst = 12'd16;
  localparam logic [CfgW-1:0] MaxLayersRst     = 12'd2048;

  // Request handed from front to back
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [FmtW-1:0] format;
    logic [CapW-1:0] capacity;
  } req_t;

  // One array table entry
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [FmtW-1:0] format;
    logic [CapW-1:0] fill;
    logic [CapW-1:0] capacity;
  } entry_t;

  // Result of a hint table lookup
  typedef struct packed {
    logic            hit;
    logic [CapW-1:0] layers;
  } hint_t;

  // Look up the layer hint for a texture size
  function automatic hint_t hint_lookup(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    hint_t r;
    r.hit    = 1'b1;
    r.layers = '0;
    case ({w, h})
      {13'd8,   13'd8}:   r.layers = 12'd16;
      {13'd16,  13'd16}:  r.layers = 12'd32;
      {13'd16,  13'd32}:  r.layers = 12'd16;
      {13'd16,  13'd64}:  r.layers = 12'd32;
      {13'd32,  13'd16}:  r.layers = 12'd16;
      {13'd32,  13'd32}:  r.layers = 12'd128;
      {13'd32,  13'd64}:  r.layers = 12'd96;
      {13'd32,  13'd128}: r.layers = 12'd64;
      {13'd32,  13'd256}: r.layers = 12'd16;
      {13'd64,  13'd16}:  r.layers = 12'd16;
      {13'd64,  13'd32}:  r.layers = 12'd48;
      {13'd64,  13'd64}:  r.layers = 12'd256;
      {13'd64,  13'd128}: r.layers = 12'd256;
      {13'd64,  13'd256}: r.layers = 12'd128;
      {13'd128, 13'd32}:  r.layers = 12'd32;
      {13'd128, 13'd64}:  r.layers = 12'd256;
      {13'd128, 13'd128}: r.layers = 12'd256;
      {13'd128, 13'd256}: r.layers = 12'd256;
      {13'd256, 13'd32}:  r.layers = 12'd16;
      {13'd256, 13'd64}:  r.layers = 12'd64;
      {13'd256, 13'd128}: r.layers = 12'd256;
      {13'd256, 13'd256}: r.layers = 12'd512;
      {13'd512, 13'd512}: r.layers = 12'd16;
      default:            r.hit    = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/tlsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tlsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tlsa_queue.sv
// Short request queue between the front and the back of the allocator.
module tlsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlsa_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tlsa_pkg::req_t head
);

  tlsa_pkg::req_t                   slots [tlsa_pkg::QueueDepth];
  logic [tlsa_pkg::QPtrW-1:0]       wr_ptr;
  logic [tlsa_pkg::QPtrW-1:0]       rd_ptr;
  logic [tlsa_pkg::QCntW-1:0]       count;

  assign full  = (count == tlsa_pkg::QCntW'(tlsa_pkg::QueueDepth));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/tlsa_front.sv
// Front of the allocator: configuration registers, input unpacking and capacity hint.
module tlsa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tlsa_pkg::InDataW-1:0]     s_tdata,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_addr,
  input  logic [tlsa_pkg::CfgW-1:0]        cfg_data,
  output logic                             push,
  output tlsa_pkg::req_t                   push_data,
  input  logic                             q_full
);

  logic [tlsa_pkg::CfgW-1:0] default_layers;
  logic [tlsa_pkg::CfgW-1:0] max_layers;
  tlsa_pkg::hint_t           hint;
  logic [tlsa_pkg::CapW-1:0] cap_raw;
  logic [tlsa_pkg::DimW-1:0] w;
  logic [tlsa_pkg::DimW-1:0] h;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_layers <= tlsa_pkg::DefaultLayersRst;
      max_layers     <= tlsa_pkg::MaxLayersRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        tlsa_pkg::CfgDefaultLayers: default_layers <= cfg_data;
        tlsa_pkg::CfgMaxLayers:     max_layers     <= cfg_data;
        default:                    default_layers <= default_layers;
      endcase
    end
  end

  assign w = s_tdata[12:0];
  assign h = s_tdata[25:13];

  // Pick capacity: hint clamped to max_layers, else default, then saturate
  always_comb begin
    hint = tlsa_pkg::hint_lookup(w, h);
    if (hint.hit) begin
      cap_raw = (max_layers < hint.layers) ? max_layers : hint.layers;
    end else begin
      cap_raw = default_layers;
    end
    push_data.width    = w;
    push_data.height   = h;
    push_data.format   = s_tdata[41:26];
    push_data.capacity = (cap_raw > tlsa_pkg::CapLimit) ? tlsa_pkg::CapLimit : cap_raw;
  end

  // Accept an item whenever the queue has room
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

endmodule

>>> rtl/core/tlsa_back.sv
// Back of the allocator: table scan, entry update and the output register.
module tlsa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  tlsa_pkg::req_t                    q_head,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tlsa_pkg::OutDataW-1:0]     m_tdata,
  output logic [tlsa_pkg::OutUserW-1:0]     m_tuser
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MISS = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                         state;
  logic [tlsa_pkg::UsedW-1:0]     entries_used;
  logic [tlsa_pkg::UsedW-1:0]     issue_idx;
  logic                           chk_valid;
  logic [tlsa_pkg::IdxW-1:0]      chk_idx;
  logic                           chk_last;

  // Result held until the output register is free
  logic [tlsa_pkg::IdxW-1:0]      res_index;
  logic [tlsa_pkg::LayerW-1:0]    res_layer;
  logic                           res_new;
  logic [tlsa_pkg::CapW-1:0]      res_cap;
  logic                           res_full;

  // Pending table write
  logic                           wr_pend;
  logic [tlsa_pkg::IdxW-1:0]      wr_addr_r;
  tlsa_pkg::entry_t               wr_data_r;

  // RAM ports
  logic                           rd_en;
  logic [tlsa_pkg::IdxW-1:0]      rd_addr;
  tlsa_pkg::entry_t               rd_data;
  logic                           wr_en;

  logic                           issue_go;
  logic                           match;
  logic                           load;

  tlsa_ram #(
    .Width ($bits(tlsa_pkg::entry_t)),
    .Depth (tlsa_pkg::MaxArrays)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr_r),
    .wdata (wr_data_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Issue one table read per cycle while entries remain
  assign issue_go = (state == S_SCAN) && (issue_idx < entries_used);
  assign rd_en    = issue_go;
  assign rd_addr  = issue_idx[tlsa_pkg::IdxW-1:0];

  // Compare the entry read last cycle
  assign match = chk_valid &&
                 (rd_data.width == q_head.width) &&
                 (rd_data.height == q_head.height) &&
                 (rd_data.format == q_head.format) &&
                 (rd_data.fill < rd_data.capacity);

  // Finish when the output register is free
  assign load  = (state == S_DONE) && (!m_tvalid || m_tready);
  assign wr_en = load && wr_pend;
  assign q_pop = load;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entries_used <= '0;
      chk_valid    <= 1'b0;
      issue_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          issue_idx <= '0;
          chk_valid <= 1'b0;
          if (q_valid) begin
            state <= (entries_used == '0) ? S_MISS : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_go) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (match) begin
            chk_valid <= 1'b0;
            state     <= S_DONE;
          end else if (chk_valid && chk_last) begin
            chk_valid <= 1'b0;
            state     <= S_MISS;
          end else begin
            chk_valid <= issue_go;
          end
        end
        S_MISS: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            if (res_new) begin
              entries_used <= entries_used + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Track the index of the entry in flight
  always_ff @(posedge clk) begin
    if (issue_go) begin
      chk_idx  <= issue_idx[tlsa_pkg::IdxW-1:0];
      chk_last <= (issue_idx == entries_used - 1'b1);
    end
  end

  // Build result and table update
  always_ff @(posedge clk) begin
    if (state == S_SCAN && match) begin
      res_index          <= chk_idx;
      res_layer          <= rd_data.fill[tlsa_pkg::LayerW-1:0];
      res_new            <= 1'b0;
      res_cap            <= '0;
      res_full           <= 1'b0;
      wr_pend            <= 1'b1;
      wr_addr_r          <= chk_idx;
      wr_data_r.width    <= rd_data.width;
      wr_data_r.height   <= rd_data.height;
      wr_data_r.format   <= rd_data.format;
      wr_data_r.fill     <= rd_data.fill + 1'b1;
      wr_data_r.capacity <= rd_data.capacity;
    end else if (state == S_MISS) begin
      res_layer <= '0;
      if (entries_used >= tlsa_pkg::UsedW'(tlsa_pkg::MaxArrays)) begin
        res_index <= '0;
        res_new   <= 1'b0;
        res_cap   <= '0;
        res_full  <= 1'b1;
        wr_pend   <= 1'b0;
      end else begin
        res_index          <= entries_used[tlsa_pkg::IdxW-1:0];
        res_new            <= 1'b1;
        res_cap            <= q_head.capacity;
        res_full           <= 1'b0;
        wr_pend            <= 1'b1;
        wr_addr_r          <= entries_used[tlsa_pkg::IdxW-1:0];
        wr_data_r.width    <= q_head.width;
        wr_data_r.height   <= q_head.height;
        wr_data_r.format   <= q_head.format;
        wr_data_r.fill     <= tlsa_pkg::CapW'(1);
        wr_data_r.capacity <= q_head.capacity;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, res_cap, res_layer, res_index};
      m_tuser <= {res_full, res_new};
    end
  end

  // Table writes happen only when a result leaves
  a_write_at_done: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_DONE))
    else $error("table write outside completion");

  // An appended entry raises the entry count by one
  a_used_grows: assert property (@(posedge clk) disable iff (rst)
    (load && res_new) |=> (entries_used == $past(entries_used) + 1'b1))
    else $error("entry count did not advance on append");

  // Pop only a queue that holds an item
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A full-table result never writes the table
  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (load && res_full) |-> !wr_en)
    else $error("table written on full result");

endmodule

>>> rtl/core/texture_layer_slot_allocator_unit.sv
// Top level of the texture layer slot allocator.
//
//  channel   signals                          role
//  s_*       s_tvalid s_tready s_tdata[47:0]  texture requests in
//  m_*       m_tvalid m_tready m_tdata[31:0]  placement results out, flags in m_tuser[1:0]
//  cfg_*     cfg_we cfg_addr cfg_data[11:0]   register writes
//
// An item passes through start, a scan with one table RAM read per entry in use up to the
// first match, the last compare, the append decision on a miss and the result load.
// Reset (rst, synchronous) empties the table count and loads the default registers.
// The two-item queue keeps accepting until full while a result waits; the back stalls only at
// the result load when m_tready holds the output register.
module texture_layer_slot_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: tex_width[12:0], tex_height[25:13], format_code[41:26], zero fill
  input  logic [tlsa_pkg::InDataW-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: array_index[5:0], layer_index[16:6], new_capacity[28:17], zero fill
  output logic [tlsa_pkg::OutDataW-1:0]    m_tdata,
  // m_tuser: new_array[0], table_full[1]
  output logic [tlsa_pkg::OutUserW-1:0]    m_tuser,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_addr,
  input  logic [tlsa_pkg::CfgW-1:0]        cfg_data
);

  logic           push;
  tlsa_pkg::req_t push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  tlsa_pkg::req_t q_head;

  tlsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tlsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tlsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
